>>> hw/rtl/lifegen_pkg.sv
// shared types and constants of the life automaton generation block
// no dependencies

package lifegen_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_BITS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
    localparam int COL_IDX_W  = $clog2(ROW_BITS);
    localparam int K_W        = $clog2(MAX_ROWS + 3);
    localparam int GEN_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MIN_SIZE = 7'd3;

    typedef logic [ROW_BITS-1:0] t_row;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_STEP    = 2'd2,
        OP_RESTORE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  row_index;
        logic [63:0] row_cells;
    } t_in_item;

    typedef struct packed {
        logic [63:0]      row_data;
        logic [GEN_W-1:0] generation;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic             idx_ok;
        logic [ROW_W-1:0] addr;
        t_row             cells;
    } t_cmd;

    typedef struct packed {
        logic [ROW_CNT_W-1:0] rows;
        logic [COL_IDX_W-1:0] col_last;
        logic                 wrap;
        t_row                 mask;
    } t_cfg_eff;

endpackage

>>> hw/rtl/lifegen_front.sv
// front part: configuration registers, size saturation and request decode
// depends on lifegen_pkg

module lifegen_front import lifegen_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output t_cmd                  o_push_cmd,
    output t_cfg_eff              o_cfg
);

    logic [CFG_DATA_W-1:0] r_num_rows;
    logic [CFG_DATA_W-1:0] r_num_cols;
    logic                  r_wrap;
    logic [COL_CNT_W-1:0]  cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_DATA_W'(MAX_ROWS);
            r_num_cols <= CFG_DATA_W'(MAX_COLS);
            r_wrap     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_ROWS:  r_num_rows <= i_cfg_data;
                CFG_NUM_COLS:  r_num_cols <= i_cfg_data;
                CFG_WRAP_MODE: r_wrap     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate sizes to the supported range
    always_comb begin
        if (r_num_rows < MIN_SIZE) begin
            o_cfg.rows = ROW_CNT_W'(MIN_SIZE);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            o_cfg.rows = ROW_CNT_W'(MAX_ROWS);
        end else begin
            o_cfg.rows = ROW_CNT_W'(r_num_rows);
        end
        if (r_num_cols < MIN_SIZE) begin
            cols = COL_CNT_W'(MIN_SIZE);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols = COL_CNT_W'(MAX_COLS);
        end else begin
            cols = COL_CNT_W'(r_num_cols);
        end
        o_cfg.col_last = COL_IDX_W'(cols - COL_CNT_W'(1));
        o_cfg.wrap     = r_wrap;
        if (32'(cols) >= ROW_BITS) begin
            o_cfg.mask = '1;
        end else begin
            o_cfg.mask = (t_row'(1) << cols) - t_row'(1);
        end
    end

    always_comb begin
        o_push_valid      = i_in_valid;
        o_in_ready        = i_push_ready;
        o_push_cmd.op     = t_op'(i_in_item.req_type);
        o_push_cmd.idx_ok = 32'(i_in_item.row_index) < MAX_ROWS;
        o_push_cmd.addr   = ROW_W'(i_in_item.row_index);
        o_push_cmd.cells  = i_in_item.row_cells & o_cfg.mask;
    end

endmodule

>>> hw/rtl/lifegen_queue.sv
// short command queue between front and back parts
// depends on lifegen_pkg

module lifegen_queue import lifegen_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd               r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = r_count != Q_CNT_W'(Q_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/lifegen_back.sv
// back part: grid memories, row-window generation sequencer, restore sweep, result register
// depends on lifegen_pkg

module lifegen_back import lifegen_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_eff  i_cfg,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RDWAIT = 5'b00010,
        ST_STEP   = 5'b00100,
        ST_COPY   = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   n_k;
    logic [GEN_W-1:0] r_gen;
    logic [GEN_W-1:0] n_gen;
    t_row             r_res_data;
    t_row             n_res_data;
    logic             r_rd_ok;
    logic             n_rd_ok;

    t_row             r_cell_mem  [MAX_ROWS];
    t_row             r_orig_mem  [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_cell_valid;
    logic [MAX_ROWS-1:0] r_orig_valid;
    t_row             r_rd_data;
    logic             r_rd_valid;
    t_row             r_orig_rd_data;
    logic             r_orig_rd_valid;

    t_row             r_win_a;
    t_row             r_win_b;
    t_row             r_row0;
    t_row             rd_row;
    t_row             cur_row;
    t_row             new_row;

    logic             cmd_pop;
    logic             out_load;
    logic             step_last;
    logic             copy_last;
    logic [ROW_W-1:0] rd_addr;
    logic [ROW_W-1:0] step_row;
    logic [ROW_W-1:0] copy_row;
    logic             cell_we;
    logic [ROW_W-1:0] cell_waddr;
    t_row             cell_wdata;
    logic             orig_we;

    logic             r_out_valid;
    t_out_item        r_out_item;

    function automatic t_row shift_w(t_row x, logic wrap, logic [COL_IDX_W-1:0] last);
        return (x << 1) | t_row'(wrap & x[last]);
    endfunction

    function automatic t_row shift_e(t_row x, logic wrap, logic [COL_IDX_W-1:0] last);
        return (x >> 1) | (t_row'(wrap & x[0]) << last);
    endfunction

    assign o_cmd_ready = r_state == ST_IDLE;
    assign cmd_pop     = i_cmd_valid && o_cmd_ready;
    assign out_load    = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);
    assign step_last   = r_k == (K_W'(i_cfg.rows) + K_W'(2));
    assign copy_last   = r_k == K_W'(MAX_ROWS);
    assign step_row    = ROW_W'(r_k - K_W'(3));
    assign copy_row    = ROW_W'(r_k - K_W'(1));

    // read address: row above the top first, then rows in order
    always_comb begin
        if (r_state == ST_STEP) begin
            if (r_k == '0) begin
                rd_addr = ROW_W'(i_cfg.rows - ROW_CNT_W'(1));
            end else begin
                rd_addr = ROW_W'(r_k - K_W'(1));
            end
        end else begin
            rd_addr = i_cmd.addr;
        end
    end

    // window stream and next-generation row
    always_comb begin
        logic [3:0] cnt;
        t_row up_w;
        t_row up_e;
        t_row mid_w;
        t_row mid_e;
        t_row dn_w;
        t_row dn_e;
        rd_row = r_rd_valid ? (r_rd_data & i_cfg.mask) : '0;
        if (r_k == K_W'(1)) begin
            cur_row = i_cfg.wrap ? rd_row : '0;
        end else if (step_last) begin
            cur_row = i_cfg.wrap ? r_row0 : '0;
        end else begin
            cur_row = rd_row;
        end
        up_w  = shift_w(r_win_a, i_cfg.wrap, i_cfg.col_last);
        up_e  = shift_e(r_win_a, i_cfg.wrap, i_cfg.col_last);
        mid_w = shift_w(r_win_b, i_cfg.wrap, i_cfg.col_last);
        mid_e = shift_e(r_win_b, i_cfg.wrap, i_cfg.col_last);
        dn_w  = shift_w(cur_row, i_cfg.wrap, i_cfg.col_last);
        dn_e  = shift_e(cur_row, i_cfg.wrap, i_cfg.col_last);
        new_row = '0;
        for (int c = 0; c < ROW_BITS; c++) begin
            cnt = 4'(up_w[c]) + 4'(r_win_a[c]) + 4'(up_e[c]) + 4'(mid_w[c])
                + 4'(mid_e[c]) + 4'(dn_w[c]) + 4'(cur_row[c]) + 4'(dn_e[c]);
            new_row[c] = (cnt == 4'd3) || (r_win_b[c] && (cnt == 4'd2));
        end
        new_row = new_row & i_cfg.mask;
    end

    // memory write selection
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = i_cmd.addr;
        cell_wdata = i_cmd.cells;
        orig_we    = 1'b0;
        if (cmd_pop && (i_cmd.op == OP_WRITE) && i_cmd.idx_ok) begin
            cell_we = 1'b1;
            orig_we = 1'b1;
        end else if ((r_state == ST_STEP) && (r_k >= K_W'(3))) begin
            cell_we    = 1'b1;
            cell_waddr = step_row;
            cell_wdata = new_row;
        end else if ((r_state == ST_COPY) && (r_k != '0)) begin
            cell_we    = 1'b1;
            cell_waddr = copy_row;
            cell_wdata = r_orig_rd_valid ? r_orig_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_waddr] <= cell_wdata;
        end
        r_rd_data <= r_cell_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (orig_we) begin
            r_orig_mem[i_cmd.addr] <= i_cmd.cells;
        end
        r_orig_rd_data <= r_orig_mem[ROW_W'(r_k)];
    end

    // row valid bits stand in for clearing the grids at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid    <= '0;
            r_orig_valid    <= '0;
            r_rd_valid      <= 1'b0;
            r_orig_rd_valid <= 1'b0;
        end else begin
            if (cell_we) begin
                r_cell_valid[cell_waddr] <= 1'b1;
            end
            if (orig_we) begin
                r_orig_valid[i_cmd.addr] <= 1'b1;
            end
            r_rd_valid      <= r_cell_valid[rd_addr];
            r_orig_rd_valid <= r_orig_valid[ROW_W'(r_k)];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_STEP) && (r_k != '0)) begin
            r_win_a <= r_win_b;
            r_win_b <= cur_row;
            if (r_k == K_W'(2)) begin
                r_row0 <= cur_row;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_gen      = r_gen;
        n_res_data = r_res_data;
        n_rd_ok    = r_rd_ok;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_pop) begin
                    n_res_data = '0;
                    n_k        = '0;
                    n_rd_ok    = i_cmd.idx_ok;
                    unique case (i_cmd.op)
                        OP_WRITE:   n_state = ST_RESULT;
                        OP_READ:    n_state = ST_RDWAIT;
                        OP_STEP:    n_state = ST_STEP;
                        OP_RESTORE: n_state = ST_COPY;
                        default:    n_state = ST_RESULT;
                    endcase
                end
            end
            ST_RDWAIT: begin
                n_res_data = r_rd_ok ? rd_row : '0;
                n_state    = ST_RESULT;
            end
            ST_STEP: begin
                n_k = r_k + K_W'(1);
                if (step_last) begin
                    n_gen   = r_gen + GEN_W'(1);
                    n_state = ST_RESULT;
                end
            end
            ST_COPY: begin
                n_k = r_k + K_W'(1);
                if (copy_last) begin
                    n_gen   = '0;
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_gen   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_gen   <= n_gen;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_data <= n_res_data;
    end

    // result register parts the back part from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.row_data   <= r_res_data;
            r_out_item.generation <= r_gen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_step_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && cell_we) |-> (ROW_CNT_W'(step_row) < i_cfg.rows))
        else $error("step writes a row outside the grid");

    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && n_state == ST_RESULT) |=> (r_gen == $past(r_gen) + GEN_W'(1)))
        else $error("generation count not advanced by a step");

    a_restore_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && n_state == ST_RESULT) |=> (r_gen == '0))
        else $error("generation count not cleared by restore");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT || r_state == ST_RESULT) |-> (!cell_we && !orig_we))
        else $error("grid written outside a request");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_out_valid && !i_out_ready) |=> (r_state == ST_RESULT))
        else $error("result dropped while output register full");

endmodule

>>> hw/rtl/life_automaton_generation.sv
// life automaton generation top: front decode, command queue, back grid engine
// step walks the window one row a cycle; restore copies row by row over the single cell write port
// reset: sizes 64 by 64, dead border, generation zero, grids read dead via row valid bits

module life_automaton_generation import lifegen_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic     push_valid;
    logic     push_ready;
    t_cmd     push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    t_cmd     pop_cmd;
    t_cfg_eff cfg;

    lifegen_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd),
        .o_cfg        (cfg)
    );

    lifegen_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    lifegen_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> bench/life_generation_checker.sv
// checker for the life automaton generation block: watches the config, request and reply channels
// keeps its own copy of both grids and the generation count, and compares each reply in order
// depends on lifegen_pkg

module life_generation_checker import lifegen_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_row                  cell_rows [MAX_ROWS];
    t_row                  saved_rows [MAX_ROWS];
    logic [GEN_W-1:0]      gen_count;
    logic [CFG_DATA_W-1:0] cfg_rows;
    logic [CFG_DATA_W-1:0] cfg_cols;
    logic                  cfg_wrap;
    t_out_item             expected_replies [$];
    int                    mismatch_count;

    function automatic int used_rows();
        if (cfg_rows < MIN_SIZE) return int'(MIN_SIZE);
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_rows);
    endfunction

    function automatic int used_cols();
        if (cfg_cols < MIN_SIZE) return int'(MIN_SIZE);
        if (cfg_cols > MAX_COLS) return MAX_COLS;
        return int'(cfg_cols);
    endfunction

    function automatic t_row live_mask(input int cols);
        if (cols >= ROW_BITS) return '1;
        return (t_row'(1) << cols) - t_row'(1);
    endfunction

    // neighbor lookup, one cell outside the used area at most
    function automatic int neighbor_alive(input int r, input int c, input int rows,
                                          input int cols);
        int rr;
        int cc;
        rr = r;
        cc = c;
        if (rr < 0 || rr >= rows) begin
            if (!cfg_wrap) return 0;
            rr = (rr < 0) ? rr + rows : rr - rows;
        end
        if (cc < 0 || cc >= cols) begin
            if (!cfg_wrap) return 0;
            cc = (cc < 0) ? cc + cols : cc - cols;
        end
        return int'(cell_rows[rr][cc]);
    endfunction

    function automatic void advance_generation();
        int   rows;
        int   cols;
        int   count;
        t_row mask;
        t_row next_row;
        t_row next_grid [MAX_ROWS];
        rows = used_rows();
        cols = used_cols();
        mask = live_mask(cols);
        for (int r = 0; r < rows; r++)
            cell_rows[r] &= mask;
        for (int r = 0; r < rows; r++) begin
            next_row = '0;
            for (int c = 0; c < cols; c++) begin
                count = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            count += neighbor_alive(r + dr, c + dc, rows, cols);
                if (count == 3 || (cell_rows[r][c] && count == 2))
                    next_row[c] = 1'b1;
            end
            next_grid[r] = next_row;
        end
        for (int r = 0; r < rows; r++)
            cell_rows[r] = next_grid[r];
        gen_count = gen_count + GEN_W'(1);
    endfunction

    function automatic t_out_item predict_reply(input t_in_item req);
        t_out_item reply;
        t_row      mask;
        mask = live_mask(used_cols());
        reply.row_data = '0;
        case (req.req_type)
            OP_WRITE: begin
                cell_rows[req.row_index]  = req.row_cells & mask;
                saved_rows[req.row_index] = req.row_cells & mask;
            end
            OP_READ: begin
                reply.row_data = cell_rows[req.row_index] & mask;
            end
            OP_STEP: begin
                advance_generation();
            end
            OP_RESTORE: begin
                cell_rows = saved_rows;
                gen_count = '0;
            end
        endcase
        reply.generation = gen_count;
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (cell_rows[r]) begin
                cell_rows[r]  = '0;
                saved_rows[r] = '0;
            end
            gen_count = '0;
            cfg_rows  = 7'd64;
            cfg_cols  = 7'd64;
            cfg_wrap  = 1'b0;
            expected_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected reply: row_data %h generation %0d",
                                 i_out_item.row_data, i_out_item.generation);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_item.row_data !== want.row_data
                            || i_out_item.generation !== want.generation) begin
                        if (mismatch_count < 10)
                            $display("mismatch: exp data %h gen %0d, got data %h gen %0d",
                                     want.row_data, want.generation,
                                     i_out_item.row_data, i_out_item.generation);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS:  cfg_rows = i_cfg_data;
                    CFG_NUM_COLS:  cfg_cols = i_cfg_data;
                    CFG_WRAP_MODE: cfg_wrap = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_replies.push_back(predict_reply(i_in_item));
        end
        o_pending    <= expected_replies.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> bench/tb_life_automaton_generation.sv
// testbench top for life_automaton_generation: drives config, requests and reply stalls
// grid tracking and reply compare live in life_generation_checker; depends on lifegen_pkg

module tb_life_automaton_generation import lifegen_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 600;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    int                    in_idle_pct = 0;
    int                    out_stall_pct = 0;
    logic                  hold_req = 1'b0;
    int                    hold_left = HOLD_CYCLES;
    int                    mismatches;
    int                    pending;

    life_automaton_generation uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    life_generation_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // reply side: long hold-off when requested, random stalls otherwise
    always @(posedge clk) begin
        if (hold_req && hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("[life_automaton_generation] ERROR");
        $finish;
    end

    function automatic t_row random_cells();
        t_row a;
        t_row b;
        t_row c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(5))
            0, 1:    return a & b & c;
            2, 3:    return a;
            4:       return a | b;
            default: return ($urandom_range(1) == 0) ? '1 : '0;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(7))
                0:       return 7'd0;
                1:       return 7'd1;
                2:       return 7'd2;
                3:       return 7'd3;
                4:       return 7'd63;
                5:       return 7'd64;
                6:       return 7'd65;
                default: return 7'd127;
            endcase
        end
        if (sel < 70) return 7'($urandom_range(3, 10));
        return 7'($urandom_range(3, 64));
    endfunction

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                in_idle_pct = 0;
                out_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                in_idle_pct = 50;
                out_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                in_idle_pct = 0;
                out_stall_pct <= 50;
            end
            default: begin
                in_idle_pct = 10;
                out_stall_pct <= 10;
            end
        endcase
    endtask

    task automatic send_req(input t_op op, input logic [5:0] idx, input t_row cells);
        t_in_item req;
        req.req_type  = op;
        req.row_index = idx;
        req.row_cells = cells;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] rows,
                                input logic [CFG_DATA_W-1:0] cols,
                                input logic wrap, input bit poke_unused);
        logic [CFG_IDX_W-1:0]  idx_list [4];
        logic [CFG_DATA_W-1:0] val_list [4];
        int                    n;
        idx_list = '{CFG_NUM_ROWS, CFG_NUM_COLS, CFG_WRAP_MODE, CFG_UNUSED};
        val_list = '{rows, cols, {6'($urandom), wrap}, 7'($urandom)};
        n = poke_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= val_list[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int                    phase;
        int                    random_sent;
        int                    body_len;
        int                    eff_rows;
        int                    sel;
        logic [CFG_DATA_W-1:0] rows_cfg;
        logic [CFG_DATA_W-1:0] cols_cfg;
        logic                  wrap_cfg;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes, dead border
        set_idling(IDLE_NONE);
        send_req(OP_READ, 6'd5, '1);
        send_req(OP_WRITE, 6'd0, '1);
        send_req(OP_WRITE, 6'd63, '1);
        send_req(OP_WRITE, 6'd31, 64'h0000_0000_0007_0000);
        send_req(OP_READ, 6'd0, '0);
        send_req(OP_READ, 6'd63, '0);
        send_req(OP_STEP, 6'd63, '1);
        send_req(OP_READ, 6'd0, '0);
        send_req(OP_READ, 6'd1, '0);
        send_req(OP_READ, 6'd31, '0);
        send_req(OP_READ, 6'd30, '0);
        send_req(OP_READ, 6'd63, '0);
        send_req(OP_RESTORE, 6'd0, '0);
        send_req(OP_READ, 6'd0, '0);
        send_req(OP_READ, 6'd31, '0);

        // sizes below and above range, toroidal wrap
        drain();
        program_regs(7'd0, 7'd127, 1'b1, 1'b1);
        send_req(OP_WRITE, 6'd0, 64'h8000_0000_0000_0001);
        send_req(OP_WRITE, 6'd1, 64'h8000_0000_0000_0003);
        send_req(OP_WRITE, 6'd2, 64'h0000_0000_0000_0002);
        send_req(OP_STEP, 6'd0, '0);
        send_req(OP_READ, 6'd0, '0);
        send_req(OP_READ, 6'd1, '0);
        send_req(OP_READ, 6'd2, '0);
        send_req(OP_STEP, 6'd0, '0);
        send_req(OP_READ, 6'd2, '0);

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            case (phase)
                0: begin
                    rows_cfg = 7'd127;
                    cols_cfg = 7'd0;
                    wrap_cfg = 1'b0;
                end
                1: begin
                    rows_cfg = 7'd3;
                    cols_cfg = 7'd64;
                    wrap_cfg = 1'b1;
                end
                default: begin
                    rows_cfg = pick_size();
                    cols_cfg = pick_size();
                    wrap_cfg = 1'($urandom);
                end
            endcase
            program_regs(rows_cfg, cols_cfg, wrap_cfg, ($urandom_range(7) == 0));
            set_idling(t_idling'(phase % 4));
            eff_rows = (rows_cfg < MIN_SIZE) ? 3 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;

            // load a fresh pattern into the rows in use
            for (int r = 0; r < eff_rows; r++) begin
                send_req(OP_WRITE, 6'(r), random_cells());
                random_sent++;
            end
            if (eff_rows < MAX_ROWS && $urandom_range(1) == 0) begin
                send_req(OP_WRITE, 6'($urandom_range(eff_rows, MAX_ROWS - 1)), random_cells());
                random_sent++;
            end

            body_len = $urandom_range(25, 60);
            for (int k = 0; k < body_len; k++) begin
                if (phase == 2 && k == 5)
                    hold_req <= 1'b1;
                if (k == body_len / 2 && (phase == 3 || $urandom_range(2) == 0))
                    drain();
                sel = $urandom_range(99);
                if (sel < 38) begin
                    send_req(OP_STEP, 6'($urandom), random_cells());
                end else if (sel < 72) begin
                    if ($urandom_range(99) < 85)
                        send_req(OP_READ, 6'($urandom_range(eff_rows - 1)), random_cells());
                    else
                        send_req(OP_READ, 6'($urandom), random_cells());
                end else if (sel < 82) begin
                    send_req(OP_WRITE, 6'($urandom_range(eff_rows - 1)), random_cells());
                end else if (sel < 87) begin
                    send_req(OP_RESTORE, 6'($urandom), random_cells());
                end else begin
                    send_req(t_op'($urandom_range(3)), 6'($urandom), random_cells());
                end
                random_sent++;
            end
            phase++;
        end

        drain();
        repeat (MAX_ROWS + 16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[life_automaton_generation] OK");
        else
            $display("[life_automaton_generation] ERROR");
        $finish;
    end

endmodule
